@@ rtl/lptc_pkg.sv @@
// Shared types, constants and the per-LED next-state function of the LED pattern timer.
package lptc_pkg;

    localparam int LED_NUM   = 2;
    localparam int LED_IDX_W = 1;
    localparam int OUT_W     = 2;
    localparam int TIME_W    = 32;
    localparam int REG_W     = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [REG_W-1:0] HB_PERIOD_RST  = 16'd1000;
    localparam logic [REG_W-1:0] HB_PULSE_RST   = 16'd100;
    localparam logic [REG_W-1:0] SLOW_BLINK_RST = 16'd500;
    localparam logic [REG_W-1:0] FAST_BLINK_RST = 16'd200;
    localparam logic [REG_W-1:0] ERR_BLINK_RST  = 16'd100;
    localparam logic [REG_W-1:0] FLASH_RST      = 16'd50;

    typedef enum logic [2:0] {
        ACT_TICK     = 3'd0,
        ACT_SET_MODE = 3'd1,
        ACT_FORCE    = 3'd2,
        ACT_TOGGLE   = 3'd3,
        ACT_FLASH    = 3'd4
    } action_t;

    typedef enum logic [2:0] {
        MODE_OFF   = 3'd0,
        MODE_ON    = 3'd1,
        MODE_HEART = 3'd2,
        MODE_SLOW  = 3'd3,
        MODE_FAST  = 3'd4,
        MODE_ERR   = 3'd5
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HB_PERIOD  = 3'd0,
        CFG_HB_PULSE   = 3'd1,
        CFG_SLOW_BLINK = 3'd2,
        CFG_FAST_BLINK = 3'd3,
        CFG_ERR_BLINK  = 3'd4,
        CFG_FLASH      = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [REG_W-1:0] hb_period;
        logic [REG_W-1:0] hb_pulse;
        logic [REG_W-1:0] slow_blink;
        logic [REG_W-1:0] fast_blink;
        logic [REG_W-1:0] err_blink;
        logic [REG_W-1:0] flash;
    } cfg_t;

    typedef struct packed {
        logic [2:0]           action;
        logic [LED_IDX_W-1:0] led_index;
        logic [2:0]           mode_code;
        logic                 level;
    } cmd_t;

    typedef struct packed {
        logic [2:0]        mode;
        logic [TIME_W-1:0] stamp;
        logic [REG_W-1:0]  interval;
        logic              phase;
        logic              pin;
        logic              active;
    } led_state_t;

    // Next state of one LED for one item. now is the time after the item,
    // so on a tick it is already the advanced count.
    function automatic led_state_t led_step(led_state_t s, cmd_t c, logic hit,
                                            logic [TIME_W-1:0] now, cfg_t cfg);
        led_state_t        n;
        logic [TIME_W-1:0] age;
        logic              int_done;
        n        = s;
        age      = now - s.stamp;
        int_done = age >= TIME_W'(s.interval);
        if (c.action == ACT_TICK)
        begin
            // Interrupt-side rules first: pulse end and flash expiry.
            if (s.active)
            begin
                if (s.mode == MODE_HEART)
                begin
                    if (s.phase && age >= TIME_W'(cfg.hb_pulse))
                    begin
                        n.phase = 1'b0;
                        n.pin   = 1'b0;
                    end
                end
                else if (s.mode == MODE_ON)
                begin
                    if (s.interval != '0 && int_done)
                    begin
                        n.phase  = 1'b0;
                        n.pin    = 1'b0;
                        n.active = 1'b0;
                    end
                end
            end
            // Then the main-loop rules: pulse start and blink toggling.
            if (n.active && int_done)
            begin
                if (s.mode == MODE_HEART)
                begin
                    n.stamp = now;
                    n.phase = 1'b1;
                    n.pin   = 1'b1;
                end
                else if (s.mode == MODE_SLOW || s.mode == MODE_FAST
                         || s.mode == MODE_ERR)
                begin
                    n.stamp = now;
                    n.phase = ~n.phase;
                    n.pin   = n.phase;
                end
            end
        end
        else if (hit)
        begin
            case (c.action)
                ACT_SET_MODE:
                begin
                    n.mode   = c.mode_code;
                    n.stamp  = now;
                    n.active = 1'b1;
                    case (c.mode_code)
                        MODE_OFF:
                        begin
                            n.active = 1'b0;
                            n.phase  = 1'b0;
                            n.pin    = 1'b0;
                        end
                        MODE_ON:
                        begin
                            n.active = 1'b0;
                            n.phase  = 1'b1;
                            n.pin    = 1'b1;
                        end
                        MODE_HEART:
                        begin
                            n.interval = cfg.hb_period;
                            n.phase    = 1'b0;
                        end
                        MODE_SLOW:
                        begin
                            n.interval = cfg.slow_blink;
                            n.phase    = 1'b0;
                        end
                        MODE_FAST:
                        begin
                            n.interval = cfg.fast_blink;
                            n.phase    = 1'b0;
                        end
                        MODE_ERR:
                        begin
                            n.interval = cfg.err_blink;
                            n.phase    = 1'b0;
                        end
                        default: ;
                    endcase
                end
                ACT_FORCE:
                begin
                    n.active = 1'b0;
                    n.phase  = c.level;
                    n.pin    = c.level;
                end
                ACT_TOGGLE:
                begin
                    n.phase = ~s.phase;
                    n.pin   = ~s.phase;
                end
                ACT_FLASH:
                begin
                    n.mode     = MODE_ON;
                    n.stamp    = now;
                    n.interval = cfg.flash;
                    n.active   = 1'b1;
                    n.phase    = 1'b1;
                    n.pin      = 1'b1;
                end
                default: ;
            endcase
        end
        return n;
    endfunction

endpackage

@@ rtl/lptc_cfg_regs.sv @@
// Configuration register file of the LED pattern timer.
module lptc_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [lptc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lptc_pkg::REG_W-1:0]     cfg_data,
    output lptc_pkg::cfg_t                 cfg
);
    import lptc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_HB_PERIOD:  cfg_next.hb_period  = cfg_data;
                CFG_HB_PULSE:   cfg_next.hb_pulse   = cfg_data;
                CFG_SLOW_BLINK: cfg_next.slow_blink = cfg_data;
                CFG_FAST_BLINK: cfg_next.fast_blink = cfg_data;
                CFG_ERR_BLINK:  cfg_next.err_blink  = cfg_data;
                CFG_FLASH:      cfg_next.flash      = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hb_period  <= HB_PERIOD_RST;
            cfg_reg.hb_pulse   <= HB_PULSE_RST;
            cfg_reg.slow_blink <= SLOW_BLINK_RST;
            cfg_reg.fast_blink <= FAST_BLINK_RST;
            cfg_reg.err_blink  <= ERR_BLINK_RST;
            cfg_reg.flash      <= FLASH_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/lptc_led_bank.sv @@
// State registers and next-state logic of all LEDs, updated in parallel.
module lptc_led_bank (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         update,
    input  lptc_pkg::cmd_t               cmd,
    input  logic [lptc_pkg::TIME_W-1:0]  now,
    input  lptc_pkg::cfg_t               cfg,
    output logic [lptc_pkg::LED_NUM-1:0] pins_next,
    output logic [lptc_pkg::LED_NUM-1:0] active_next
);
    import lptc_pkg::*;

    led_state_t state_reg  [LED_NUM];
    led_state_t state_next [LED_NUM];

    for (genvar i = 0; i < LED_NUM; i++)
    begin : g_led
        always_comb
        begin
            state_next[i] = led_step(state_reg[i], cmd,
                                     cmd.led_index == LED_IDX_W'(i), now, cfg);
        end

        // The first LED comes out of reset running the heartbeat.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                state_reg[i].mode     <= (i == 0) ? MODE_HEART : MODE_OFF;
                state_reg[i].stamp    <= '0;
                state_reg[i].interval <= (i == 0) ? HB_PERIOD_RST : '0;
                state_reg[i].phase    <= 1'b0;
                state_reg[i].pin      <= 1'b0;
                state_reg[i].active   <= (i == 0);
            end
            else if (update)
            begin
                state_reg[i] <= state_next[i];
            end
        end

        assign pins_next[i]   = state_next[i].pin;
        assign active_next[i] = state_next[i].active;
    end

endmodule

@@ rtl/led_pattern_timer_controller.sv @@
// Top level of the LED pattern timer: input register, time base and result register.
//
// Items enter on in_valid/in_stall; each carries a tick or a command for one LED.
// Every accepted item gives exactly one result on out_valid/out_stall: the LED
// levels, the timed-control flags and the tick count as they stand after it.
// The item is first held in the input register; when the result register is
// free, the LED next-state logic (one 32-bit subtract and compare per LED)
// writes the state and the result register together. Throughput is one item per
// cycle while the result side does not stall; the subtract-and-compare of each LED is
// the longest path. in_stall rises only while the input register holds an
// item that cannot move because the result register is full and stalled;
// nothing is dropped and a waiting result holds steady.
// Configuration is written through cfg_write_en, cfg_index and cfg_data; the user must
// write it only while no item is in flight, which the block itself does not enforce;
// writes to unused indexes are ignored. After reset both channels are empty, time is
// zero, the first LED runs the heartbeat and the second is off; registers hold their documented defaults.
module led_pattern_timer_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [2:0]                     action,
    input  logic [lptc_pkg::LED_IDX_W-1:0] led_index,
    input  logic [2:0]                     mode_code,
    input  logic                           level,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [lptc_pkg::OUT_W-1:0]     led_levels,
    output logic [lptc_pkg::OUT_W-1:0]     auto_active,
    output logic [lptc_pkg::TIME_W-1:0]    time_now,
    input  logic                           cfg_write_en,
    input  logic [lptc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lptc_pkg::REG_W-1:0]     cfg_data
);
    import lptc_pkg::*;

    cfg_t               cfg;
    logic               in_valid_reg;
    cmd_t               item_reg;
    logic [TIME_W-1:0]  tick_reg;
    logic [TIME_W-1:0]  tick_next;
    logic               out_valid_reg;
    logic [OUT_W-1:0]   led_levels_reg;
    logic [OUT_W-1:0]   auto_active_reg;
    logic [TIME_W-1:0]  time_now_reg;
    logic [LED_NUM-1:0] pins_next;
    logic [LED_NUM-1:0] active_next;
    logic               out_free;
    logic               advance;
    logic               accept;

    lptc_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    // The held item moves on when the result register is empty or being taken.
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign accept    = in_valid && !in_stall;
    assign tick_next = (item_reg.action == ACT_TICK) ? tick_reg + 1'b1 : tick_reg;

    lptc_led_bank u_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .update      (advance),
        .cmd         (item_reg),
        .now         (tick_next),
        .cfg         (cfg),
        .pins_next   (pins_next),
        .active_next (active_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tick_reg      <= '0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.action    <= action;
            item_reg.led_index <= led_index;
            item_reg.mode_code <= mode_code;
            item_reg.level     <= level;
        end
        if (advance)
        begin
            led_levels_reg  <= pins_next[OUT_W-1:0];
            auto_active_reg <= active_next[OUT_W-1:0];
            time_now_reg    <= tick_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign led_levels  = led_levels_reg;
    assign auto_active = auto_active_reg;
    assign time_now    = time_now_reg;

endmodule

@@ test/lptc_checker.sv @@
// Result checker for the LED pattern timer: follows accepted items, predicts each result, compares.
module lptc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic [2:0]                     action,
    input  logic [lptc_pkg::LED_IDX_W-1:0] led_index,
    input  logic [2:0]                     mode_code,
    input  logic                           level,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [lptc_pkg::OUT_W-1:0]     led_levels,
    input  logic [lptc_pkg::OUT_W-1:0]     auto_active,
    input  logic [lptc_pkg::TIME_W-1:0]    time_now,
    input  logic                           cfg_write_en,
    input  logic [lptc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lptc_pkg::REG_W-1:0]     cfg_data,
    output int                             mismatches,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lptc_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0]  lit;
        logic [OUT_W-1:0]  timed;
        logic [TIME_W-1:0] now;
    } led_view_t;

    led_view_t views_due[$];

    // Timer settings as the block should hold them.
    logic [REG_W-1:0] hb_period, hb_pulse, slow_half, fast_half, err_half, flash_len;

    // Per-LED state of the predicted block.
    logic [TIME_W-1:0] ticks;
    logic [2:0]        led_mode_q  [LED_NUM];
    logic [TIME_W-1:0] since       [LED_NUM];
    logic [REG_W-1:0]  span        [LED_NUM];
    logic              phase_q     [LED_NUM];
    logic              pin_q       [LED_NUM];
    logic              timed_q     [LED_NUM];

    function automatic bit aged(int i, logic [REG_W-1:0] limit);
        logic [TIME_W-1:0] gone;
        gone = ticks - since[i];
        return gone >= TIME_W'(limit);
    endfunction

    task automatic light(int i, logic v);
        pin_q[i]   = v;
        phase_q[i] = v;
    endtask

    task automatic clear_leds();
        ticks     = '0;
        hb_period = HB_PERIOD_RST;
        hb_pulse  = HB_PULSE_RST;
        slow_half = SLOW_BLINK_RST;
        fast_half = FAST_BLINK_RST;
        err_half  = ERR_BLINK_RST;
        flash_len = FLASH_RST;
        for (int i = 0; i < LED_NUM; i++)
        begin
            led_mode_q[i] = MODE_OFF;
            since[i]      = '0;
            span[i]       = '0;
            phase_q[i]    = 1'b0;
            pin_q[i]      = 1'b0;
            timed_q[i]    = 1'b0;
        end
        led_mode_q[0] = MODE_HEART;
        span[0]       = hb_period;
        timed_q[0]    = 1'b1;
    endtask

    task automatic step_leds(logic [2:0] act, int idx, logic [2:0] m, logic lv);
        if (act == ACT_TICK)
        begin
            ticks = ticks + 1;
            // Pulse ends and flash expiry are settled for every LED before any pulse starts.
            for (int i = 0; i < LED_NUM; i++)
            begin
                if (timed_q[i])
                begin
                    if (led_mode_q[i] == MODE_HEART)
                    begin
                        if (phase_q[i] && aged(i, hb_pulse))
                            light(i, 1'b0);
                    end
                    else if (led_mode_q[i] == MODE_ON)
                    begin
                        if (span[i] != '0 && aged(i, span[i]))
                        begin
                            light(i, 1'b0);
                            timed_q[i] = 1'b0;
                        end
                    end
                end
            end
            for (int i = 0; i < LED_NUM; i++)
            begin
                if (timed_q[i] && aged(i, span[i]))
                begin
                    if (led_mode_q[i] == MODE_HEART)
                    begin
                        since[i] = ticks;
                        light(i, 1'b1);
                    end
                    else if (led_mode_q[i] == MODE_SLOW || led_mode_q[i] == MODE_FAST
                             || led_mode_q[i] == MODE_ERR)
                    begin
                        since[i] = ticks;
                        light(i, ~phase_q[i]);
                    end
                end
            end
        end
        else if (idx < LED_NUM)
        begin
            case (act)
                ACT_SET_MODE:
                begin
                    led_mode_q[idx] = m;
                    since[idx]      = ticks;
                    timed_q[idx]    = 1'b1;
                    case (m)
                        MODE_OFF:
                        begin
                            timed_q[idx] = 1'b0;
                            light(idx, 1'b0);
                        end
                        MODE_ON:
                        begin
                            timed_q[idx] = 1'b0;
                            light(idx, 1'b1);
                        end
                        MODE_HEART:
                        begin
                            span[idx]    = hb_period;
                            phase_q[idx] = 1'b0;
                        end
                        MODE_SLOW:
                        begin
                            span[idx]    = slow_half;
                            phase_q[idx] = 1'b0;
                        end
                        MODE_FAST:
                        begin
                            span[idx]    = fast_half;
                            phase_q[idx] = 1'b0;
                        end
                        MODE_ERR:
                        begin
                            span[idx]    = err_half;
                            phase_q[idx] = 1'b0;
                        end
                        default: ;
                    endcase
                end
                ACT_FORCE:
                begin
                    timed_q[idx] = 1'b0;
                    light(idx, lv);
                end
                ACT_TOGGLE:
                    light(idx, ~phase_q[idx]);
                ACT_FLASH:
                begin
                    led_mode_q[idx] = MODE_ON;
                    since[idx]      = ticks;
                    span[idx]       = flash_len;
                    timed_q[idx]    = 1'b1;
                    light(idx, 1'b1);
                end
                default: ;
            endcase
        end
    endtask

    function automatic led_view_t current_view();
        led_view_t v;
        v.lit   = '0;
        v.timed = '0;
        v.now   = ticks;
        for (int i = 0; i < LED_NUM && i < OUT_W; i++)
        begin
            v.lit[i]   = pin_q[i];
            v.timed[i] = timed_q[i];
        end
        return v;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        led_view_t seen;
        led_view_t want;
        if (!rst_n)
        begin
            clear_leds();
            views_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{lit: led_levels, timed: auto_active, now: time_now};
                if (views_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: result with nothing expected: levels=%b active=%b time=%0d",
                                 $realtime, seen.lit, seen.timed, seen.now);
                end
                else
                begin
                    want = views_due.pop_front();
                    if (seen.lit !== want.lit || seen.timed !== want.timed
                        || seen.now !== want.now)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch: levels %b/%b active %b/%b time %0d/%0d (exp/got)",
                                     $realtime, want.lit, seen.lit, want.timed, seen.timed,
                                     want.now, seen.now);
                    end
                end
            end
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_HB_PERIOD:  hb_period = cfg_data;
                    CFG_HB_PULSE:   hb_pulse  = cfg_data;
                    CFG_SLOW_BLINK: slow_half = cfg_data;
                    CFG_FAST_BLINK: fast_half = cfg_data;
                    CFG_ERR_BLINK:  err_half  = cfg_data;
                    CFG_FLASH:      flash_len = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                step_leds(action, int'(led_index), mode_code, level);
                views_due.push_back(current_view());
            end
        end
        pending = views_due.size();
    end

endmodule

@@ test/led_pattern_timer_controller_tb.sv @@
// Testbench top for the LED pattern timer: clock, reset, timer settings, item and stall traffic.
module led_pattern_timer_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lptc_pkg::*;

    typedef enum int {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_PERIODIC} flow_t;

    localparam int PHASES         = 6;
    localparam int ITEMS_PER_PHASE = 255;
    localparam int LONG_HOLD      = 60;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [2:0]           action;
    logic [LED_IDX_W-1:0] led_index;
    logic [2:0]           mode_code;
    logic                 level;
    logic                 out_valid;
    logic                 out_stall;
    logic [OUT_W-1:0]     led_levels;
    logic [OUT_W-1:0]     auto_active;
    logic [TIME_W-1:0]    time_now;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_data;
    int                   mismatches;
    int                   pending;

    int burst_left = 0;
    bit no_gaps    = 1'b0;
    int holds_req  = 0;
    int holds_done = 0;

    led_pattern_timer_controller dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .led_index   (led_index),
        .mode_code   (mode_code),
        .level       (level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .led_levels  (led_levels),
        .auto_active (auto_active),
        .time_now    (time_now),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    lptc_checker view_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .led_index   (led_index),
        .mode_code   (mode_code),
        .level       (level),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .led_levels  (led_levels),
        .auto_active (auto_active),
        .time_now    (time_now),
        .cfg_write_en(cfg_write_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: switches between random stall styles, and serves long hold-offs on request.
    initial
    begin
        flow_t style;
        int    style_left;
        int    hold_left;
        style      = FLOW_FREE;
        style_left = 0;
        hold_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (holds_req > holds_done)
            begin
                holds_done++;
                hold_left = LONG_HOLD - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                if (style_left == 0)
                begin
                    style      = flow_t'($urandom_range(FLOW_FREE, FLOW_PERIODIC));
                    style_left = $urandom_range(10, 60);
                end
                style_left--;
                case (style)
                    FLOW_FREE:   out_stall <= 1'b0;
                    FLOW_LIGHT:  out_stall <= ($urandom_range(0, 9) < 3);
                    FLOW_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= (style_left % 3 == 0);
                endcase
            end
        end
    end

    // Called and returns at a falling edge; holds the item until the block takes it.
    task automatic send_item(logic [2:0] act, logic idx, logic [2:0] m, logic lv);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = (no_gaps || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        action    <= act;
        led_index <= idx;
        mode_code <= m;
        level     <= lv;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Mostly ticks and blink set-ups so that the timed rules fire; the rest is commands and noise.
    task automatic random_item();
        int         pick;
        logic [2:0] act;
        logic [2:0] m;
        pick = $urandom_range(0, 99);
        m    = 3'($urandom_range(0, 7));
        if (pick < 55)
            act = ACT_TICK;
        else if (pick < 70)
        begin
            act = ACT_SET_MODE;
            if ($urandom_range(0, 3) != 0)
                m = 3'($urandom_range(MODE_HEART, MODE_ERR));
        end
        else if (pick < 78)
            act = ACT_FORCE;
        else if (pick < 86)
            act = ACT_TOGGLE;
        else if (pick < 97)
            act = ACT_FLASH;
        else
            act = 3'($urandom_range(int'(ACT_FLASH) + 1, 7));
        send_item(act, 1'($urandom_range(0, 1)), m, 1'($urandom_range(0, 1)));
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [REG_W-1:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= value;
        @(negedge clk);
    endtask

    task automatic program_timers(logic [REG_W-1:0] hp, logic [REG_W-1:0] pw,
                                  logic [REG_W-1:0] sl, logic [REG_W-1:0] fa,
                                  logic [REG_W-1:0] er, logic [REG_W-1:0] fl);
        write_reg(CFG_HB_PERIOD, hp);
        write_reg(CFG_HB_PULSE, pw);
        write_reg(CFG_SLOW_BLINK, sl);
        write_reg(CFG_FAST_BLINK, fa);
        write_reg(CFG_ERR_BLINK, er);
        write_reg(CFG_FLASH, fl);
        cfg_write_en <= 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = ACT_TICK;
        led_index    = '0;
        mode_code    = MODE_OFF;
        level        = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index    = CFG_HB_PERIOD;
        cfg_data     = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset settings: every command, both LEDs, unused codes.
        send_item(ACT_TICK, 1'b0, MODE_OFF, 1'b0);
        send_item(ACT_SET_MODE, 1'b1, MODE_SLOW, 1'b1);
        send_item(ACT_SET_MODE, 1'b1, MODE_FAST, 1'b0);
        send_item(ACT_SET_MODE, 1'b1, MODE_ERR, 1'b1);
        send_item(ACT_SET_MODE, 1'b1, MODE_HEART, 1'b0);
        send_item(ACT_SET_MODE, 1'b0, MODE_ON, 1'b1);
        send_item(ACT_SET_MODE, 1'b0, MODE_OFF, 1'b0);
        for (int m = int'(MODE_ERR) + 1; m < 8; m++)
            send_item(ACT_SET_MODE, m[0], m[2:0], 1'b1);
        send_item(ACT_TICK, 1'b1, MODE_ERR, 1'b1);
        send_item(ACT_FORCE, 1'b0, MODE_OFF, 1'b1);
        send_item(ACT_FORCE, 1'b1, MODE_OFF, 1'b0);
        send_item(ACT_TOGGLE, 1'b0, MODE_OFF, 1'b0);
        send_item(ACT_TOGGLE, 1'b1, MODE_OFF, 1'b0);
        send_item(ACT_FLASH, 1'b1, MODE_OFF, 1'b0);
        send_item(ACT_FLASH, 1'b0, MODE_OFF, 1'b0);
        send_item(ACT_TICK, 1'b0, MODE_OFF, 1'b0);
        for (int a = int'(ACT_FLASH) + 1; a < 8; a++)
            send_item(a[2:0], 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                      1'($urandom_range(0, 1)));
        send_item(ACT_SET_MODE, 1'b0, MODE_HEART, 1'b0);
        repeat (3) send_item(ACT_TICK, 1'b0, MODE_OFF, 1'b0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            drain();
            case (phase)
                0: program_timers(16'd8, 16'd3, 16'd4, 16'd2, 16'd1, 16'd3);
                1: program_timers('0, '0, '0, '0, '0, '0);
                2: program_timers('1, '1, '1, '1, '1, '1);
                3: program_timers(REG_W'($urandom_range(0, 9)), REG_W'($urandom_range(0, 9)),
                                  REG_W'($urandom_range(0, 9)), REG_W'($urandom_range(0, 9)),
                                  REG_W'($urandom_range(0, 9)), REG_W'($urandom_range(0, 9)));
                4: program_timers(16'd2, 16'd5, 16'd1, 16'd3, 16'd6, 16'd0);
                default: program_timers(REG_W'($urandom_range(1, 16)),
                                        REG_W'($urandom_range(1, 16)),
                                        REG_W'($urandom_range(1, 16)),
                                        REG_W'($urandom_range(1, 16)),
                                        REG_W'($urandom_range(1, 16)),
                                        REG_W'($urandom_range(1, 16)));
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Once, flood the block while the result side holds off, then let it run dry.
                if (phase == 0 && n == 100)
                begin
                    no_gaps = 1'b1;
                    holds_req++;
                end
                if (phase == 0 && n == 140)
                begin
                    no_gaps = 1'b0;
                    drain();
                end
                random_item();
            end
        end

        drain();
        repeat (8) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
